// ===== sv/rfbt_pkg.sv =====
// ----------------------------------------------------------------------------
// rfbt_pkg: shared definitions of the register family busy tracker
// Family counts, field widths, command and status codes, sequencer states
// and the write port type of the busy order list.
// ----------------------------------------------------------------------------
package rfbt_pkg;

  localparam int GENERAL_FAMILIES = 8;
  localparam int NUM_FAMILIES     = GENERAL_FAMILIES + 1;

  // Field widths fixed by the interface.
  localparam int CMD_W  = 3;
  localparam int FAM_W  = 4;
  localparam int SIZE_W = 2;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 4;
  localparam int STAT_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND_FREE    = 3'd0,
    CMD_MARK_BUSY    = 3'd1,
    CMD_POP_LAST     = 3'd2,
    CMD_POP_INDEX    = 3'd3,
    CMD_POP_FAMILY   = 3'd4,
    CMD_RELEASE_AUTO = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK           = 3'd0,
    STATUS_NONE_FREE    = 3'd1,
    STATUS_ALREADY_BUSY = 3'd2,
    STATUS_LIST_EMPTY   = 3'd3,
    STATUS_BAD_INDEX    = 3'd4,
    STATUS_NOT_FOUND    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SEARCH,
    ST_POP,
    ST_SHIFT,
    ST_COMPACT
  } state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [FAM_W-1:0] data;
  } list_wr_t;

endpackage

// ===== sv/register_family_busy_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// register_family_busy_tracker_unit: family allocator with ordered busy list
// Finds free families, marks them busy and pops or releases them in order.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; its result appears
// on the result ports for exactly one cycle with done_o high, and the receiver
// cannot stall it. Mark busy, and any command rejected at once (empty list,
// bad index, unknown command), shows its result in the cycle after the item is
// taken. Find free checks the busy flags of the eight general families in turn;
// the other commands walk the nine-entry busy order list through its single
// read port, one entry per cycle: pop last and pop index free the entry and move
// later entries down, pop family searches for the family first, release auto frees
// entries whose mask bit is clear. A new item is taken in the result cycle.
module register_family_busy_tracker_unit
  import rfbt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              manual_free_mask_we_i,
  input  logic [8:0]        manual_free_mask_i,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [FAM_W-1:0]  family_i,
  input  logic [SIZE_W-1:0] size_code_i,
  input  logic [IDX_W-1:0]  list_index_i,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [FAM_W-1:0]  result_family_o,
  output logic [SIZE_W-1:0] result_size_o,
  output logic [CNT_W-1:0]  busy_count_o
);

  state_e state_q, state_d;

  logic [NUM_FAMILIES-1:0] mask_q;
  logic [NUM_FAMILIES-1:0] fbusy_q, fbusy_d;
  logic [SIZE_W-1:0]       fsize_q [NUM_FAMILIES];
  logic [SIZE_W-1:0]       fsize_d [NUM_FAMILIES];
  logic [CNT_W-1:0]        len_q, len_d;
  logic [IDX_W-1:0]        ptr_q, ptr_d;
  logic [IDX_W-1:0]        wr_q, wr_d;
  logic [FAM_W-1:0]        fam_q, fam_d;
  logic [SIZE_W-1:0]       size_q, size_d;
  logic                    done_q, done_d;
  logic [STAT_W-1:0]       status_q, status_d;
  logic [FAM_W-1:0]        rfam_q, rfam_d;
  logic [SIZE_W-1:0]       rsize_q, rsize_d;

  list_wr_t         list_wr;
  logic [IDX_W-1:0] rd_addr;
  logic [FAM_W-1:0] list_rd;
  logic [IDX_W-1:0] ptr_nx;
  logic [IDX_W-1:0] wr_nx;
  logic             last;
  logic             keep;
  logic             accept;

  rfbt_order_list u_list (
    .clk_i   (clk_i),
    .wr_i    (list_wr),
    .raddr_i (rd_addr),
    .rdata_o (list_rd)
  );

  assign accept = start_i && (state_q == ST_IDLE);
  assign ptr_nx = ptr_q + IDX_W'(1);
  assign last   = (CNT_W'(ptr_nx) >= len_q);
  assign keep   = mask_q[list_rd];
  assign wr_nx  = wr_q + IDX_W'(keep);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_FIND_FREE:    state_d = ST_FIND;
            CMD_POP_LAST:     if (len_q != '0) state_d = ST_POP;
            CMD_POP_INDEX: begin
              if ((len_q != '0) && (CNT_W'(list_index_i) < len_q)) state_d = ST_POP;
            end
            CMD_POP_FAMILY:   if (len_q != '0) state_d = ST_SEARCH;
            CMD_RELEASE_AUTO: if (len_q != '0) state_d = ST_COMPACT;
            default:          state_d = ST_IDLE;
          endcase
        end
      end
      ST_FIND: begin
        if (!fbusy_q[ptr_q] || (ptr_q == IDX_W'(GENERAL_FAMILIES - 1))) state_d = ST_IDLE;
      end
      ST_SEARCH: begin
        if (list_rd == fam_q) state_d = ST_POP;
        else if (last)        state_d = ST_IDLE;
      end
      ST_POP:     state_d = ST_SHIFT;
      ST_SHIFT:   if (last) state_d = ST_IDLE;
      ST_COMPACT: if (last) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and results.
  always_comb begin
    ptr_d    = ptr_q;
    wr_d     = wr_q;
    len_d    = len_q;
    fbusy_d  = fbusy_q;
    fsize_d  = fsize_q;
    fam_d    = fam_q;
    size_d   = size_q;
    done_d   = 1'b0;
    status_d = status_q;
    rfam_d   = rfam_q;
    rsize_d  = rsize_q;
    rd_addr  = ptr_q;
    list_wr  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fam_d    = family_i;
          size_d   = size_code_i;
          status_d = STATUS_OK;
          rfam_d   = '0;
          rsize_d  = '0;
          ptr_d    = '0;
          wr_d     = '0;
          case (cmd_e'(command_i))
            CMD_FIND_FREE: begin
            end
            CMD_MARK_BUSY: begin
              done_d = 1'b1;
              if (family_i >= FAM_W'(NUM_FAMILIES)) begin
                status_d = STATUS_NOT_FOUND;
              end else if (fbusy_q[family_i]) begin
                status_d = STATUS_ALREADY_BUSY;
              end else if (len_q < CNT_W'(NUM_FAMILIES)) begin
                fbusy_d[family_i] = 1'b1;
                fsize_d[family_i] = size_code_i;
                list_wr.we        = 1'b1;
                list_wr.addr      = IDX_W'(len_q);
                list_wr.data      = family_i;
                len_d             = len_q + CNT_W'(1);
                rfam_d            = family_i;
                rsize_d           = size_code_i;
              end
            end
            CMD_POP_LAST: begin
              if (len_q == '0) begin
                done_d   = 1'b1;
                status_d = STATUS_LIST_EMPTY;
              end else begin
                ptr_d = IDX_W'(len_q - CNT_W'(1));
              end
            end
            CMD_POP_INDEX: begin
              if (len_q == '0) begin
                done_d   = 1'b1;
                status_d = STATUS_LIST_EMPTY;
              end else if (CNT_W'(list_index_i) >= len_q) begin
                done_d   = 1'b1;
                status_d = STATUS_BAD_INDEX;
              end else begin
                ptr_d = list_index_i;
              end
            end
            CMD_POP_FAMILY: begin
              if (len_q == '0) begin
                done_d   = 1'b1;
                status_d = STATUS_NOT_FOUND;
              end
            end
            CMD_RELEASE_AUTO: begin
              if (len_q == '0) done_d = 1'b1;
            end
            default: begin
              // Unknown commands answer ok and leave the state alone.
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_FIND: begin
        if (!fbusy_q[ptr_q]) begin
          done_d  = 1'b1;
          rfam_d  = FAM_W'(ptr_q);
          rsize_d = size_q;
        end else if (ptr_q == IDX_W'(GENERAL_FAMILIES - 1)) begin
          done_d   = 1'b1;
          status_d = STATUS_NONE_FREE;
        end else begin
          ptr_d = ptr_nx;
        end
      end
      ST_SEARCH: begin
        if (list_rd != fam_q) begin
          if (last) begin
            done_d   = 1'b1;
            status_d = STATUS_NOT_FOUND;
          end else begin
            ptr_d = ptr_nx;
          end
        end
      end
      ST_POP: begin
        rfam_d           = list_rd;
        rsize_d          = fsize_q[list_rd];
        fbusy_d[list_rd] = 1'b0;
      end
      ST_SHIFT: begin
        // Close the gap: each later entry moves down by one position.
        rd_addr = ptr_nx;
        if (last) begin
          len_d  = len_q - CNT_W'(1);
          done_d = 1'b1;
        end else begin
          list_wr.we   = 1'b1;
          list_wr.addr = ptr_q;
          list_wr.data = list_rd;
          ptr_d        = ptr_nx;
        end
      end
      ST_COMPACT: begin
        if (keep) begin
          list_wr.we   = 1'b1;
          list_wr.addr = wr_q;
          list_wr.data = list_rd;
        end else begin
          fbusy_d[list_rd] = 1'b0;
        end
        if (last) begin
          len_d  = CNT_W'(wr_nx);
          done_d = 1'b1;
        end else begin
          ptr_d = ptr_nx;
          wr_d  = wr_nx;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mask_q  <= '0;
      fbusy_q <= '0;
      len_q   <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < NUM_FAMILIES; i++) begin
        fsize_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      fbusy_q <= fbusy_d;
      fsize_q <= fsize_d;
      len_q   <= len_d;
      done_q  <= done_d;
      if (manual_free_mask_we_i) begin
        mask_q <= manual_free_mask_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    wr_q     <= wr_d;
    fam_q    <= fam_d;
    size_q   <= size_d;
    status_q <= status_d;
    rfam_q   <= rfam_d;
    rsize_q  <= rsize_d;
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign result_family_o = rfam_q;
  assign result_size_o   = rsize_q;
  assign busy_count_o    = len_q;

`ifndef SYNTH
  a_done_in_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe outside idle");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(NUM_FAMILIES))
    else $error("busy list longer than the family count");

  a_busy_matches_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(fbusy_q) == int'(len_q)))
    else $error("busy flags disagree with the list length");

  a_shift_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (CNT_W'(ptr_q) < len_q))
    else $error("gap close pointer beyond the list");
`endif

endmodule

// ===== sv/rfbt_order_list.sv =====
// ----------------------------------------------------------------------------
// rfbt_order_list: busy order list storage
// Nine family entries, oldest first, with one write and one read port.
// ----------------------------------------------------------------------------
module rfbt_order_list
  import rfbt_pkg::*;
(
  input  logic             clk_i,
  input  list_wr_t         wr_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [FAM_W-1:0] rdata_o
);

  logic [FAM_W-1:0] entry_q [NUM_FAMILIES];

  // Entries hold no reset value; only entries below the list length are used.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      entry_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rdata_o = entry_q[raddr_i];

endmodule
